[hw/rtl/stf_pkg.sv]
// Shared types, token kinds, scanner states and byte classifiers for the source tokenizer.
// Depends on nothing; every other file of the block but stf_if imports it.
`default_nettype none
package stf_pkg;

	typedef enum logic [4:0] {
		ST_START, ST_WS, ST_COMMENT, ST_EQ, ST_INT, ST_FRAC_SYM, ST_FRAC, ST_EXP_SYM,
		ST_EXP, ST_IDENT, ST_STR, ST_STR_ESC, ST_CH, ST_CH_ESC, ST_CH_GOT
	} scan_state_t;

	localparam logic [4:0] K_END     = 5'd0;
	localparam logic [4:0] K_STAR    = 5'd1;
	localparam logic [4:0] K_COMMENT = 5'd2;
	localparam logic [4:0] K_DOT     = 5'd3;
	localparam logic [4:0] K_SEMI    = 5'd4;
	localparam logic [4:0] K_COLON   = 5'd5;
	localparam logic [4:0] K_ASSIGN  = 5'd6;
	localparam logic [4:0] K_LPAREN  = 5'd7;
	localparam logic [4:0] K_RPAREN  = 5'd8;
	localparam logic [4:0] K_COMMA   = 5'd9;
	localparam logic [4:0] K_LBRACK  = 5'd10;
	localparam logic [4:0] K_RBRACK  = 5'd11;
	localparam logic [4:0] K_LBRACE  = 5'd12;
	localparam logic [4:0] K_RBRACE  = 5'd13;
	localparam logic [4:0] K_INT     = 5'd14;
	localparam logic [4:0] K_FLOAT   = 5'd15;
	localparam logic [4:0] K_IDENT   = 5'd16;
	localparam logic [4:0] K_STRING  = 5'd17;
	localparam logic [4:0] K_CHAR    = 5'd18;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] line;
		logic [15:0] col;
		logic [7:0]  len;
		logic        err;
	} res_t;

	// One queue entry holds every result that a single word produced.
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	function automatic logic is_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_id_start(logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b == CH_SP || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic [2:0] utf8_len(logic [7:0] b);
		if (b < 8'h80) return 3'd1;
		if (b >= 8'hC0 && b <= 8'hDF) return 3'd2;
		if (b >= 8'hE0 && b <= 8'hEF) return 3'd3;
		if (b >= 8'hF0 && b <= 8'hF7) return 3'd4;
		return 3'd0;
	endfunction

	function automatic logic [4:0] single_kind(logic [7:0] b);
		unique case (b)
			8'h2A: return K_STAR;
			8'h2E: return K_DOT;
			8'h3B: return K_SEMI;
			8'h3A: return K_COLON;
			8'h28: return K_LPAREN;
			8'h29: return K_RPAREN;
			8'h2C: return K_COMMA;
			8'h5B: return K_LBRACK;
			8'h5D: return K_RBRACK;
			8'h7B: return K_LBRACE;
			8'h7D: return K_RBRACE;
			default: return K_END;
		endcase
	endfunction

endpackage
`default_nettype wire

[hw/rtl/stf_if.sv]
// Valid/ready channel interfaces for source bytes and for token results.
// Standalone; no package needed.
`default_nettype none
interface stf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;
	modport source(output valid, byte_in, end_of_input, input ready);
	modport sink(input valid, byte_in, end_of_input, output ready);
endinterface

interface stf_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [7:0]  token_length;
	logic        is_error;
	logic        last_of_run;
	modport source(output valid, token_kind, start_line, start_column, token_length,
		is_error, last_of_run, input ready);
	modport sink(input valid, token_kind, start_line, start_column, token_length,
		is_error, last_of_run, output ready);
endinterface
`default_nettype wire

[hw/rtl/stf_front.sv]
// Front end: scanner FSM, a byte per cycle when room is set, packing each byte's results.
// Depends on stf_pkg and stf_in_if.
`default_nettype none
module stf_front #(
	parameter int MAX_TOKEN_LEN = 255,
	parameter int POSITION_BITS = 16
) (
	input  wire               clk,
	input  wire               arst_n,
	stf_in_if.sink            in_ch,
	input  wire               room,
	output stf_pkg::entry_t   entry,
	output logic              push
);
	import stf_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [PB-1:0] PMAX = {PB{1'b1}};

	scan_state_t   st_q, nst, t_st;
	logic [4:0]    pk_q, npk;
	logic [PB-1:0] tl_q, tc_q, cl_q, cc_q, ntl, ntc, ncl, ncc;
	logic [LW-1:0] len_q, nlen;
	logic [1:0]    u8_q, nu8, t_u8;
	logic [1:0]    n;
	res_t          r0, r1, er;
	logic          do_take, t_emit, do_emit, e_err, reexam, do_adv, acc;
	logic [4:0]    sk;
	logic [2:0]    seq;
	logic [7:0]    b;

	function automatic res_t mk(logic [4:0] k, logic [PB-1:0] l, logic [PB-1:0] c,
		logic [LW-1:0] ln, logic e);
		res_t r;
		r.kind = k;
		r.line = (32'(l) > 32'hFFFF) ? 16'hFFFF : 16'(l);
		r.col  = (32'(c) > 32'hFFFF) ? 16'hFFFF : 16'(c);
		r.len  = (32'(ln) > 32'hFF) ? 8'hFF : 8'(ln);
		r.err  = e;
		return r;
	endfunction

	// Position update for one consumed byte; line in the upper half.
	function automatic logic [2*PB-1:0] adv(logic [7:0] c, logic [PB-1:0] l,
		logic [PB-1:0] col);
		logic [PB-1:0] nl, nc;
		nl = l;
		nc = col;
		if (c == CH_NL) begin
			if (l < PMAX) nl = l + 1'b1;
			nc = PB'(1);
		end else if (col < PMAX) begin
			nc = col + 1'b1;
		end
		return {nl, nc};
	endfunction

	assign b = in_ch.byte_in;
	assign acc = in_ch.valid && room;
	assign in_ch.ready = room;
	assign seq = utf8_len(b);
	assign sk = single_kind(b);

	always_comb begin
		nst = st_q; npk = pk_q; ntl = tl_q; ntc = tc_q;
		ncl = cl_q; ncc = cc_q; nlen = len_q; nu8 = u8_q;
		n = 2'd0; r0 = '0; r1 = '0; er = '0;
		do_take = 1'b0; t_st = st_q; t_u8 = u8_q; t_emit = 1'b0;
		do_emit = 1'b0; e_err = 1'b0; reexam = 1'b0; do_adv = 1'b0;
		if (in_ch.end_of_input) begin
			case (st_q) inside
				ST_COMMENT, ST_EQ, ST_INT, ST_FRAC, ST_EXP, ST_IDENT: begin
					r0 = mk(pk_q, tl_q, tc_q, len_q, 1'b0);
					n = 2'd1;
				end
				ST_FRAC_SYM, ST_EXP_SYM, ST_STR, ST_STR_ESC, ST_CH, ST_CH_ESC,
				ST_CH_GOT: begin
					r0 = mk(pk_q, tl_q, tc_q, len_q, 1'b1);
					n = 2'd1;
				end
				default: ;
			endcase
			er = mk(K_END, cl_q, cc_q, '0, 1'b0);
			if (n == 2'd0) r0 = er; else r1 = er;
			n = n + 2'd1;
			nst = ST_START; npk = K_END; ntl = PB'(1); ntc = PB'(1);
			ncl = PB'(1); ncc = PB'(1); nlen = '0; nu8 = 2'd0;
		end else begin
			unique case (st_q)
				ST_WS: begin
					if (is_space(b)) do_adv = 1'b1;
					else reexam = 1'b1;
				end
				ST_COMMENT: begin
					if (b == CH_CR || b == CH_NL) begin
						do_emit = 1'b1; reexam = 1'b1;
					end else do_take = 1'b1;
				end
				ST_EQ: begin
					if (b == CH_EQ) begin
						do_take = 1'b1; t_emit = 1'b1;
					end else begin
						do_emit = 1'b1; reexam = 1'b1;
					end
				end
				ST_INT: begin
					if (b == CH_E) begin
						npk = K_FLOAT; do_take = 1'b1; t_st = ST_EXP_SYM;
					end else if (b == CH_DOT) begin
						npk = K_FLOAT; do_take = 1'b1; t_st = ST_FRAC_SYM;
					end else if (is_digit(b)) do_take = 1'b1;
					else begin
						do_emit = 1'b1; reexam = 1'b1;
					end
				end
				ST_FRAC_SYM: begin
					if (is_digit(b)) begin
						do_take = 1'b1; t_st = ST_FRAC;
					end else begin
						do_emit = 1'b1; e_err = 1'b1; reexam = 1'b1;
					end
				end
				ST_FRAC: begin
					if (b == CH_E || b == CH_UE) begin
						do_take = 1'b1; t_st = ST_EXP_SYM;
					end else if (is_digit(b)) do_take = 1'b1;
					else begin
						do_emit = 1'b1; reexam = 1'b1;
					end
				end
				ST_EXP_SYM: begin
					if (b >= CH_ONE && b <= CH_NINE) begin
						do_take = 1'b1; t_st = ST_EXP;
					end else begin
						do_emit = 1'b1; e_err = 1'b1; reexam = 1'b1;
					end
				end
				ST_EXP: begin
					if (is_digit(b)) do_take = 1'b1;
					else begin
						do_emit = 1'b1; reexam = 1'b1;
					end
				end
				ST_IDENT: begin
					if (u8_q != 2'd0) begin
						do_take = 1'b1; t_u8 = u8_q - 2'd1;
					end else if (is_id_start(b) || is_digit(b)) do_take = 1'b1;
					else if (seq > 3'd1) begin
						do_take = 1'b1; t_u8 = 2'(seq - 3'd1);
					end else begin
						do_emit = 1'b1; reexam = 1'b1;
					end
				end
				ST_STR: begin
					do_take = 1'b1;
					if (u8_q != 2'd0) t_u8 = u8_q - 2'd1;
					else if (b == CH_BSL) t_st = ST_STR_ESC;
					else if (b == CH_DQ) t_emit = 1'b1;
					else t_u8 = (seq > 3'd0) ? 2'(seq - 3'd1) : 2'd0;
				end
				ST_STR_ESC: begin
					do_take = 1'b1; t_st = ST_STR;
				end
				ST_CH: begin
					if (b == CH_BSL) begin
						do_take = 1'b1; t_st = ST_CH_ESC;
					end else if (b == CH_SQ) begin
						do_emit = 1'b1; e_err = 1'b1; reexam = 1'b1;
					end else begin
						do_take = 1'b1; t_st = ST_CH_GOT;
					end
				end
				ST_CH_ESC: begin
					do_take = 1'b1; t_st = ST_CH_GOT;
				end
				ST_CH_GOT: begin
					if (b == CH_SQ) begin
						do_take = 1'b1; t_emit = 1'b1;
					end else begin
						do_emit = 1'b1; e_err = 1'b1; reexam = 1'b1;
					end
				end
				default: ;
			endcase

			if (do_adv || do_take) {ncl, ncc} = adv(b, cl_q, cc_q);
			if (do_take) begin
				// A byte past the length limit is dropped and closes the token as an error.
				if (32'(len_q) >= 32'(MAX_TOKEN_LEN)) begin
					r0 = mk(npk, tl_q, tc_q, len_q, 1'b1);
					n = 2'd1;
					nst = ST_START; nu8 = 2'd0;
				end else begin
					nlen = len_q + 1'b1;
					nst = t_st; nu8 = t_u8;
					if (t_emit) begin
						r0 = mk(npk, tl_q, tc_q, nlen, 1'b0);
						n = 2'd1;
						nst = ST_START; nu8 = 2'd0;
					end
				end
			end
			if (do_emit) begin
				r0 = mk(npk, tl_q, tc_q, len_q, e_err);
				n = 2'd1;
				nst = ST_START; nu8 = 2'd0;
			end

			// The start state sees either a fresh byte or the byte that closed a token.
			if (st_q == ST_START || reexam) begin
				nu8 = 2'd0;
				if (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_NL) begin
					{ncl, ncc} = adv(b, ncl, ncc);
					nst = ST_WS;
				end else begin
					ntl = ncl; ntc = ncc; nlen = LW'(1);
					{ncl, ncc} = adv(b, ncl, ncc);
					nst = ST_START;
					if (b < 8'h80 && sk != K_END) begin
						npk = sk;
						er = mk(sk, ntl, ntc, nlen, 1'b0);
					end else if (b == CH_HASH) begin
						npk = K_COMMENT; nst = ST_COMMENT;
					end else if (b == CH_EQ) begin
						npk = K_ASSIGN; nst = ST_EQ;
					end else if (b == CH_SQ) begin
						npk = K_CHAR; nst = ST_CH;
					end else if (b == CH_DQ) begin
						npk = K_STRING; nst = ST_STR;
					end else if (is_digit(b)) begin
						npk = K_INT; nst = ST_INT;
					end else if (is_id_start(b)) begin
						npk = K_IDENT; nst = ST_IDENT;
					end else if (seq > 3'd1) begin
						npk = K_IDENT; nst = ST_IDENT; nu8 = 2'(seq - 3'd1);
					end else begin
						npk = K_END;
						er = mk(K_END, ntl, ntc, nlen, 1'b1);
					end
					if (nst == ST_START) begin
						if (n == 2'd0) r0 = er; else r1 = er;
						n = n + 2'd1;
					end
				end
			end
		end
	end

	assign push = acc && n != 2'd0;
	assign entry.two = n == 2'd2;
	assign entry.r0 = r0;
	assign entry.r1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_START; pk_q <= K_END;
			tl_q <= PB'(1); tc_q <= PB'(1); cl_q <= PB'(1); cc_q <= PB'(1);
			len_q <= '0; u8_q <= 2'd0;
		end else if (acc) begin
			st_q <= nst; pk_q <= npk; tl_q <= ntl; tc_q <= ntc;
			cl_q <= ncl; cc_q <= ncc; len_q <= nlen; u8_q <= nu8;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/stf_back.sv]
// Back end: a short entry queue and an output register that sends results one word at a time.
// Depends on stf_pkg and stf_out_if.
`default_nettype none
module stf_back (
	input  wire              clk,
	input  wire              arst_n,
	input  stf_pkg::entry_t  entry,
	input  wire              push,
	output logic             room,
	stf_out_if.source        out_ch
);
	import stf_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          sub_q, ovalid_q, olast_q, load, pop;
	res_t          ores_q, head_res;
	entry_t        head;

	assign room = cnt_q != (AW+1)'(DEPTH);
	assign head = mem_q[rd_q];
	assign head_res = sub_q ? head.r1 : head.r0;
	assign load = cnt_q != '0 && (!ovalid_q || out_ch.ready);
	// The entry leaves once its last result is loaded into the output register.
	assign pop = load && (sub_q || !head.two);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= entry;
		if (load) begin
			ores_q <= head_res;
			olast_q <= sub_q || !head.two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= 1'b0; ovalid_q <= 1'b0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
			if (load) sub_q <= !pop;
			if (load) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.token_kind = ores_q.kind;
	assign out_ch.start_line = ores_q.line;
	assign out_ch.start_column = ores_q.col;
	assign out_ch.token_length = ores_q.len;
	assign out_ch.is_error = ores_q.err;
	assign out_ch.last_of_run = olast_q;

endmodule
`default_nettype wire

[hw/rtl/source_tokenizer_fsm_unit.sv]
// Top level of the source tokenizer: scanner front end feeding a result queue and output stage.
// Depends on stf_pkg, stf_if, stf_front and stf_back.
//
//  channel  | dir | word contents
//  in_ch    | in  | byte_in, end_of_input
//  out_ch   | out | token_kind, start_line, start_column, token_length, is_error, last_of_run
//
// The scanner takes one input word per cycle while the queue has room; its state machine
// decides each byte in one step. A byte yields zero, one or two results; the output stage
// sends one result word per cycle while out_ch is ready, so a byte with two results sends
// them in turn, and a four-entry queue absorbs the backlog.
// Reset puts the scanner in its start state at line 1, column 1 and empties the queue.
// Input is stalled only while the queue is full; output stalls hold the output register.
`default_nettype none
module source_tokenizer_fsm_unit #(
	parameter int MAX_TOKEN_LEN = 255,
	parameter int POSITION_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	stf_in_if.sink     in_ch,
	stf_out_if.source  out_ch
);
	import stf_pkg::*;

	entry_t entry;
	logic   push, room;

	stf_front #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN),
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .room(room), .entry(entry), .push(push)
	);

	stf_back u_back (
		.clk(clk), .arst_n(arst_n), .entry(entry), .push(push), .room(room), .out_ch(out_ch)
	);

endmodule
`default_nettype wire
